// File: design/dmf_pkg.sv
// ----------------------------------------------------------------------------
// dmf_pkg
// Types and constants for the max-flow / min-cut engine.
// ----------------------------------------------------------------------------
`default_nettype none
package dmf_pkg;
  localparam int NODES      = 32;
  localparam int EDGE_PAIRS = 256;
  localparam int NODE_W     = $clog2(NODES);
  localparam int NCNT_W     = $clog2(NODES + 1);
  localparam int PAIR_W     = $clog2(EDGE_PAIRS);
  localparam int PCNT_W     = $clog2(EDGE_PAIRS + 1);
  localparam int EDGE_W     = PAIR_W + 1;
  localparam int PTR_W      = EDGE_W + 1;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] KIND_FLOW = 2'd0;
  localparam logic [1:0] KIND_MARK = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;

  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_SINK   = 2'd1;
  localparam logic [1:0] REG_NODES  = 2'd2;
  localparam logic [1:0] REG_MINRES = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  from_node;
    logic [4:0]  to_node;
    logic [31:0] capacity;
    logic [31:0] reverse_capacity;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  node;
    logic        sink_side;
    logic [47:0] flow_value;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  from_node;
    logic [4:0]  to_node;
    logic [31:0] cap_fwd;
    logic [31:0] cap_rev;
    logic [32:0] flow;
  } pair_t;
endpackage
`default_nettype wire

// File: design/dinic_max_flow_min_cut.sv
// ----------------------------------------------------------------------------
// dinic_max_flow_min_cut
// Dinic max flow over an edge-pair memory, with sink-side cut marks.
// ----------------------------------------------------------------------------
//  channel  ports                          beat accepted when
//  input    start, busy, in_data           start && !busy
//  result   out_strobe, out_data           out_strobe (one cycle, no stall)
//  config   cfg_valid, cfg_ready, cfg_*    cfg_valid && cfg_ready
//
//  Add and clear do not leave idle; a full-table error is registered and shows in the following cycle.
//  A solve walks the pair memory one pair at a time: each BFS pop scans
//  all pairs, each DFS step scans from the node pointer, each augment reads
//  and rewrites the path. Then one flow beat and node_count mark beats follow.
//  Reset is synchronous; the edge memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module dinic_max_flow_min_cut (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  dmf_pkg::in_item_t    in_data,
  output logic                 out_strobe,
  output dmf_pkg::out_item_t   out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [1:0]            cfg_index,
  input  wire [31:0]           cfg_data
);
  import dmf_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_BFS_INIT = 4'd1;
  localparam logic [3:0] S_BFS_POP  = 4'd2;
  localparam logic [3:0] S_BFS_RD   = 4'd3;
  localparam logic [3:0] S_BFS_CK   = 4'd4;
  localparam logic [3:0] S_SRCH_ST  = 4'd5;
  localparam logic [3:0] S_SRCH_RD  = 4'd6;
  localparam logic [3:0] S_SRCH_CK  = 4'd7;
  localparam logic [3:0] S_RETREAT  = 4'd8;
  localparam logic [3:0] S_BOT_RD   = 4'd9;
  localparam logic [3:0] S_BOT_CK   = 4'd10;
  localparam logic [3:0] S_APP_RD   = 4'd11;
  localparam logic [3:0] S_APP_WR   = 4'd12;
  localparam logic [3:0] S_OUT_TOT  = 4'd13;
  localparam logic [3:0] S_OUT_MARK = 4'd14;

  logic [3:0]        state_r;
  logic [NODE_W-1:0] src_r, snk_r;
  logic [5:0]        ncfg_r;
  logic [31:0]       minres_r;
  logic [PCNT_W-1:0] pcnt_r;
  logic [47:0]       total_r;

  pair_t             mem [EDGE_PAIRS];
  pair_t             rd_q;
  logic [PAIR_W-1:0] rd_addr;
  logic              wr_en;
  logic [PAIR_W-1:0] wr_addr;
  pair_t             wr_data;

  logic              lay_vld_r [NODES];
  logic [NODE_W-1:0] lay_val_r [NODES];
  logic [PTR_W-1:0]  ptr_r     [NODES];
  logic [NODE_W-1:0] queue_r   [NODES];
  logic [NODE_W-1:0] stk_u_r   [NODES];
  logic [EDGE_W-1:0] stk_e_r   [NODES];

  logic [NCNT_W-1:0] qhead_r, qtail_r, depth_r, idx_r;
  logic [NODE_W-1:0] u_r, lu_r;
  logic [PAIR_W:0]   pidx_r;
  logic [PTR_W-1:0]  ed_r;
  logic [33:0]       bot_r;

  out_item_t         out_r;
  logic              out_v_r;

  logic [NCNT_W-1:0] n_live;
  logic [PTR_W-1:0]  slots;
  logic [33:0]       need, resf, resr, rsel;
  logic [NODE_W-1:0] v_sel, lay_addr, stk_addr, tail_v;
  logic              lay_vld_q;
  logic [NODE_W-1:0] lay_val_q;
  logic [NODE_W-1:0] stk_u_q;
  logic [EDGE_W-1:0] stk_e_q;
  logic              ev_ok, od_ok, to_in, fr_in;

  always_comb begin
    if (ncfg_r == 6'd0) n_live = NCNT_W'(1);
    else if (ncfg_r > 6'(NODES)) n_live = NCNT_W'(NODES);
    else n_live = NCNT_W'(ncfg_r);
    slots = PTR_W'({pcnt_r, 1'b0});
    need  = (minres_r == 32'd0) ? 34'd1 : {2'b00, minres_r};
    resf  = 34'($signed({2'b00, rd_q.cap_fwd}) - $signed({rd_q.flow[32], rd_q.flow}));
    resr  = 34'($signed({2'b00, rd_q.cap_rev}) + $signed({rd_q.flow[32], rd_q.flow}));
    to_in = {1'b0, rd_q.to_node} < n_live;
    fr_in = {1'b0, rd_q.from_node} < n_live;
    v_sel = (rd_q.from_node == u_r && !(state_r == S_SRCH_CK && ed_r[0]))
            ? rd_q.to_node : rd_q.from_node;
    unique case (state_r)
      S_BFS_POP:  lay_addr = queue_r[qhead_r[NODE_W-1:0]];
      S_OUT_MARK: lay_addr = idx_r[NODE_W-1:0];
      default:    lay_addr = v_sel;
    endcase
    lay_vld_q = lay_vld_r[lay_addr];
    lay_val_q = lay_val_r[lay_addr];
    stk_addr  = (state_r == S_RETREAT) ? NODE_W'(depth_r - NCNT_W'(1))
                                       : idx_r[NODE_W-1:0];
    stk_u_q   = stk_u_r[stk_addr];
    stk_e_q   = stk_e_r[stk_addr];
    rsel      = stk_e_q[0] ? resr : resf;
    tail_v    = queue_r[qhead_r[NODE_W-1:0]];
    unique case (state_r)
      S_BFS_RD:                     rd_addr = pidx_r[PAIR_W-1:0];
      S_SRCH_RD:                    rd_addr = ed_r[PTR_W-2:1];
      default:                      rd_addr = stk_e_q[EDGE_W-1:1];
    endcase
    ev_ok = 1'b0;
    od_ok = 1'b0;
    if (state_r == S_SRCH_CK) begin
      ev_ok = !ed_r[0] && rd_q.from_node == u_r && to_in && $signed(resf) >= $signed(need)
              && lay_vld_q && {1'b0, lay_val_q} == {1'b0, lu_r} + (NODE_W+1)'(1);
      od_ok = rd_q.to_node == u_r && fr_in && $signed(resr) >= $signed(need)
              && lay_vld_q && {1'b0, lay_val_q} == {1'b0, lu_r} + (NODE_W+1)'(1);
    end else begin
      ev_ok = rd_q.from_node == u_r && to_in && $signed(resf) >= $signed(need);
      od_ok = rd_q.from_node != u_r && rd_q.to_node == u_r && fr_in
              && $signed(resr) >= $signed(need);
    end
    wr_en   = 1'b0;
    wr_addr = rd_addr;
    wr_data = rd_q;
    if (state_r == S_IDLE && start && in_data.operation == OP_ADD
        && pcnt_r < PCNT_W'(EDGE_PAIRS)) begin
      wr_en             = 1'b1;
      wr_addr           = pcnt_r[PAIR_W-1:0];
      wr_data.from_node = in_data.from_node;
      wr_data.to_node   = in_data.to_node;
      wr_data.cap_fwd   = in_data.capacity;
      wr_data.cap_rev   = in_data.reverse_capacity;
      wr_data.flow      = 33'd0;
    end else if (state_r == S_APP_WR) begin
      wr_en        = 1'b1;
      wr_data.flow = stk_e_q[0] ? rd_q.flow - bot_r[32:0] : rd_q.flow + bot_r[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_v_r;
  assign out_data   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      state_r  <= S_IDLE;
      src_r    <= '0;
      snk_r    <= NODE_W'(31);
      ncfg_r   <= 6'd32;
      minres_r <= 32'd1;
      pcnt_r   <= '0;
      total_r  <= '0;
      for (int i = 0; i < NODES; i++) begin
        lay_vld_r[i] <= 1'b0;
        ptr_r[i]     <= '0;
      end
    end else begin
      out_v_r <= (state_r == S_OUT_TOT) || (state_r == S_OUT_MARK)
                 || (state_r == S_IDLE && start && in_data.operation == OP_ADD
                     && pcnt_r >= PCNT_W'(EDGE_PAIRS));
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SOURCE: src_r    <= cfg_data[NODE_W-1:0];
          REG_SINK:   snk_r    <= cfg_data[NODE_W-1:0];
          REG_NODES:  ncfg_r   <= cfg_data[5:0];
          REG_MINRES: minres_r <= cfg_data;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            unique case (in_data.operation)
              OP_ADD: begin
                if (pcnt_r < PCNT_W'(EDGE_PAIRS)) pcnt_r <= pcnt_r + PCNT_W'(1);
                else begin
                  out_r   <= '{kind: KIND_FULL, node: '0, sink_side: 1'b0,
                               flow_value: '0, last: 1'b1};
                end
              end
              OP_CLEAR: pcnt_r <= '0;
              OP_SOLVE: begin
                total_r <= '0;
                state_r <= S_BFS_INIT;
              end
              default: ;
            endcase
          end
        end
        S_BFS_INIT: begin
          for (int i = 0; i < NODES; i++)
            lay_vld_r[i] <= ({1'b0, src_r} < n_live) && (src_r == NODE_W'(i));
          qhead_r <= '0;
          if ({1'b0, src_r} < n_live) begin
            lay_val_r[src_r] <= '0;
            queue_r[0]       <= src_r;
            qtail_r          <= NCNT_W'(1);
          end else qtail_r <= '0;
          state_r <= S_BFS_POP;
        end
        S_BFS_POP: begin
          if (qhead_r < qtail_r) begin
            u_r     <= tail_v;
            lu_r    <= lay_val_q;
            qhead_r <= qhead_r + NCNT_W'(1);
            pidx_r  <= '0;
            state_r <= S_BFS_RD;
          end else if ({1'b0, src_r} >= n_live || {1'b0, snk_r} >= n_live
                       || src_r == snk_r || !lay_vld_r[snk_r]) begin
            state_r <= S_OUT_TOT;
          end else begin
            for (int i = 0; i < NODES; i++) ptr_r[i] <= '0;
            u_r     <= src_r;
            lu_r    <= '0;
            depth_r <= '0;
            state_r <= S_SRCH_ST;
          end
        end
        S_BFS_RD: begin
          state_r <= (pidx_r >= (PAIR_W+1)'(pcnt_r)) ? S_BFS_POP : S_BFS_CK;
        end
        S_BFS_CK: begin
          if ((ev_ok || od_ok) && !lay_vld_q) begin
            lay_vld_r[v_sel] <= 1'b1;
            lay_val_r[v_sel] <= lu_r + NODE_W'(1);
            if (qtail_r < NCNT_W'(NODES)) begin
              queue_r[qtail_r[NODE_W-1:0]] <= v_sel;
              qtail_r <= qtail_r + NCNT_W'(1);
            end
          end
          pidx_r  <= pidx_r + (PAIR_W+1)'(1);
          state_r <= S_BFS_RD;
        end
        S_SRCH_ST: begin
          if (u_r == snk_r) begin
            idx_r   <= '0;
            state_r <= S_BOT_RD;
          end else begin
            ed_r    <= ptr_r[u_r];
            state_r <= S_SRCH_RD;
          end
        end
        S_SRCH_RD: begin
          if (ed_r >= slots) begin
            ptr_r[u_r] <= slots;
            state_r    <= (depth_r == '0) ? S_BFS_INIT : S_RETREAT;
          end else state_r <= S_SRCH_CK;
        end
        S_SRCH_CK: begin
          if (ev_ok || od_ok) begin
            ptr_r[u_r] <= ev_ok ? ed_r : {ed_r[PTR_W-1:1], 1'b1};
            stk_u_r[depth_r[NODE_W-1:0]] <= u_r;
            stk_e_r[depth_r[NODE_W-1:0]] <= ev_ok ? ed_r[EDGE_W-1:0]
                                                  : {ed_r[EDGE_W-1:1], 1'b1};
            depth_r <= depth_r + NCNT_W'(1);
            u_r     <= v_sel;
            lu_r    <= lu_r + NODE_W'(1);
            state_r <= S_SRCH_ST;
          end else begin
            ed_r    <= {ed_r[PTR_W-1:1] + (PTR_W-1)'(1), 1'b0};
            state_r <= S_SRCH_RD;
          end
        end
        S_RETREAT: begin
          ptr_r[stk_u_q] <= PTR_W'(stk_e_q) + PTR_W'(1);
          u_r     <= stk_u_q;
          lu_r    <= lu_r - NODE_W'(1);
          depth_r <= depth_r - NCNT_W'(1);
          state_r <= S_SRCH_ST;
        end
        S_BOT_RD: state_r <= S_BOT_CK;
        S_BOT_CK: begin
          if (idx_r == '0 || $signed(rsel) < $signed(bot_r)) bot_r <= rsel;
          if (idx_r + NCNT_W'(1) == depth_r) begin
            idx_r   <= '0;
            state_r <= S_APP_RD;
          end else begin
            idx_r   <= idx_r + NCNT_W'(1);
            state_r <= S_BOT_RD;
          end
        end
        S_APP_RD: state_r <= S_APP_WR;
        S_APP_WR: begin
          if (idx_r + NCNT_W'(1) == depth_r) begin
            total_r <= total_r + {15'd0, bot_r[32:0]};
            u_r     <= src_r;
            lu_r    <= '0;
            depth_r <= '0;
            state_r <= S_SRCH_ST;
          end else begin
            idx_r   <= idx_r + NCNT_W'(1);
            state_r <= S_APP_RD;
          end
        end
        S_OUT_TOT: begin
          out_r   <= '{kind: KIND_FLOW, node: '0, sink_side: 1'b0,
                       flow_value: total_r, last: 1'b0};
          idx_r   <= '0;
          state_r <= S_OUT_MARK;
        end
        S_OUT_MARK: begin
          out_r   <= '{kind: KIND_MARK, node: idx_r[NODE_W-1:0], sink_side: !lay_vld_q,
                       flow_value: '0, last: (idx_r + NCNT_W'(1) == n_live)};
          idx_r   <= idx_r + NCNT_W'(1);
          if (idx_r + NCNT_W'(1) == n_live) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
